// ===== hdl/msc_pkg.sv =====
// Shared constants and types of the smooth escape-count block.
// No dependencies; used by every module under hdl.
package msc_pkg;

    // fixed-point formats
    localparam int FRACTION_BITS = 24;
    localparam int COUNT_BITS    = 10;
    localparam int LOG_FRAC      = 24;
    localparam int IN_W          = 32;
    localparam int IN_FRAC       = 29;

    // datapath widths
    localparam int HALF_W = 32;
    localparam int Z_W    = 2 * HALF_W;
    localparam int WIDE_W = 2 * Z_W;
    localparam int VAL_W  = 48;

    // log2(ln 2) - 1 with LOG_FRAC fraction bits
    localparam logic signed [VAL_W-1:0] LOG_CONST = -48'sd25648444;

    // configuration port
    localparam int LIMIT_W    = 10;
    localparam int RADIUS_W   = 25;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 25;
    localparam logic [CFG_ADDR_W-1:0] CFG_ITER_LIMIT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS     = 1'd1;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 10'd800;
    localparam logic [RADIUS_W-1:0]   RADIUS_RESET   = 25'd262144;

    // result widths
    localparam int SMOOTH_W = 28;
    localparam int RESID_W  = 24;

    typedef logic [HALF_W-1:0]   half_t;
    typedef logic [2*HALF_W-1:0] prod_t;

endpackage

// ===== hdl/msc_mul.sv =====
// Shared 32x32 unsigned multiplier with registered product.
// Depends on msc_pkg.
module msc_mul (
    input  logic           aclk,
    input  msc_pkg::half_t a,
    input  msc_pkg::half_t b,
    output msc_pkg::prod_t p
);
    import msc_pkg::*;

    // one partial product per cycle
    always_ff @(posedge aclk) begin
        p <= prod_t'(a) * prod_t'(b);
    end

endmodule

// ===== hdl/mandelbrot_smooth_escape.sv =====
// Smooth escape count of z -> z*z + c; one request in flight, sequenced over msc_mul.
// A point that never escapes iterates until the count reaches limit; an iteration skips
// partial products that are zero while |z| stays small. An escaped point adds two further
// iterations and six log2 evaluations of 24 squarings each, all on the one multiplier.
// A new request is taken only after the last result is loaded; s_ready only in idle. Sync active-low reset.
module mandelbrot_smooth_escape (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [msc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [msc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [msc_pkg::IN_W-1:0]     s_c_real,
    input  logic signed [msc_pkg::IN_W-1:0]     s_c_imag,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [msc_pkg::LIMIT_W-1:0]         m_iteration_count,
    output logic                                m_escaped,
    output logic signed [msc_pkg::SMOOTH_W-1:0] m_smooth_count,
    output logic signed [msc_pkg::RESID_W-1:0]  m_first_residual,
    output logic signed [msc_pkg::RESID_W-1:0]  m_second_residual,
    output logic signed [msc_pkg::SMOOTH_W-1:0] m_corrected_count
);
    import msc_pkg::*;

    localparam int C_UP        = (FRACTION_BITS >= IN_FRAC) ? FRACTION_BITS - IN_FRAC : 0;
    localparam int C_DN        = (FRACTION_BITS >= IN_FRAC) ? 0 : IN_FRAC - FRACTION_BITS;
    localparam int RAD_SH      = 2 * FRACTION_BITS - 16;
    localparam int SH_W        = $clog2(WIDE_W);
    localparam int NORM_STAGES = SH_W;
    localparam int STG_W       = $clog2(NORM_STAGES);
    localparam int STEP_W      = $clog2(LOG_FRAC + 1);
    localparam int DIFF_W      = SH_W + 2;
    localparam int Q_SH        = LOG_FRAC - 16;

    typedef enum logic [4:0] {
        S_IDLE, S_IT_RR, S_IT_II, S_IT_RI, S_IT_NR, S_IT_NI, S_IT_CHK, S_IT_CMP,
        S_LG_START, S_LG_NORM, S_LG_SQ, S_LG_UPD, S_LG_END,
        S_MUL, S_MULW, S_FIN1, S_FIN2
    } state_t;

    typedef enum logic [1:0] {PH_LOOP, PH_G0, PH_G1, PH_G2} phase_t;

    // control
    state_t state_reg, state_next, ret_reg, ret_next;
    phase_t phase_reg, phase_next;
    logic [LIMIT_W-1:0]  limit_cfg_reg, limit_cfg_next;
    logic [RADIUS_W-1:0] radius_reg, radius_next;
    logic                m_valid_reg, m_valid_next;

    // iteration datapath
    logic signed [Z_W-1:0] cr_reg, cr_next, ci_reg, ci_next;
    logic signed [Z_W-1:0] re_reg, re_next, im_reg, im_next, nr_reg, nr_next;
    logic                  neg_reg, neg_next, escaped_reg, escaped_next;
    logic [COUNT_BITS-1:0] count_reg, count_next, limit_reg, limit_next;
    logic [WIDE_W-1:0]     tmp_reg, tmp_next, acc_reg, acc_next, lv_reg, lv_next;

    // multiply sequencer
    logic [Z_W-1:0] opa_reg, opa_next, opb_reg, opb_next;
    logic [1:0]     k_reg, k_next, pend_sh_reg, pend_sh_next;
    logic           pend_vld_reg, pend_vld_next;

    // log2 unit
    logic [SH_W-1:0]     sh_reg, sh_next, p_reg, p_next;
    logic [STG_W-1:0]    stage_reg, stage_next;
    logic [Z_W-1:0]      x_reg, x_next;
    logic [LOG_FRAC-1:0] frac_reg, frac_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                second_reg, second_next;

    // log terms and rounded results
    logic signed [VAL_W-1:0] g0_reg, g0_next, g1_reg, g1_next, g2_reg, g2_next;
    logic signed [VAL_W-1:0] mu_reg, mu_next, r0_reg, r0_next, r1_reg, r1_next;

    // output registers
    logic [LIMIT_W-1:0]         oc_reg, oc_next;
    logic                       oe_reg, oe_next;
    logic signed [SMOOTH_W-1:0] osm_reg, osm_next, ocr_reg, ocr_next;
    logic signed [RESID_W-1:0]  or0_reg, or0_next, or1_reg, or1_next;

    // combinational temporaries
    half_t                   mul_a, mul_b;
    prod_t                   mul_p;
    logic signed [Z_W-1:0]   c_re_ext, c_im_ext;
    logic [WIDE_W-1:0]       addend, diff_w, signed_p, rad_wide, shifted;
    logic                    topz, nxt_found;
    logic [1:0]              nxt_k;
    int                      amt;
    logic [SH_W-1:0]         sh_new;
    logic signed [DIFF_W-1:0] lg_diff;
    logic signed [VAL_W-1:0] lg_res, lg_l, cnt_val, c16;
    logic [COUNT_BITS-1:0]   cnt_inc;

    function automatic logic [Z_W-1:0] mag(input logic signed [Z_W-1:0] v);
        return v[Z_W-1] ? Z_W'(-v) : Z_W'(v);
    endfunction

    function automatic logic part_needed(input logic [1:0] k, input logic a_nz,
                                         input logic b_nz);
        return (!k[1] || a_nz) && (!k[0] || b_nz);
    endfunction

    // round half up from LOG_FRAC to 16 fraction bits
    function automatic logic signed [VAL_W-1:0] to_q16(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] t;
        t = v + (VAL_W'(1) <<< (Q_SH - 1));
        return t >>> Q_SH;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_w(input logic signed [VAL_W-1:0] v,
                                                      input int w);
        logic signed [VAL_W-1:0] hi, lo;
        hi = (VAL_W'(1) <<< (w - 1)) - VAL_W'(1);
        lo = -hi - VAL_W'(1);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    msc_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    assign mul_a = k_reg[1] ? opa_reg[Z_W-1:HALF_W] : opa_reg[HALF_W-1:0];
    assign mul_b = k_reg[0] ? opb_reg[Z_W-1:HALF_W] : opb_reg[HALF_W-1:0];

    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_iteration_count = oc_reg;
    assign m_escaped         = oe_reg;
    assign m_smooth_count    = osm_reg;
    assign m_first_residual  = or0_reg;
    assign m_second_residual = or1_reg;
    assign m_corrected_count = ocr_reg;

    // input point to the z format
    assign c_re_ext = (Z_W'(s_c_real) <<< C_UP) >>> C_DN;
    assign c_im_ext = (Z_W'(s_c_imag) <<< C_UP) >>> C_DN;
    assign rad_wide = WIDE_W'(radius_reg) << RAD_SH;

    // partial product aligned for accumulation
    always_comb begin
        case (pend_sh_reg)
            2'd0:    addend = WIDE_W'(mul_p);
            2'd1:    addend = WIDE_W'(mul_p) << HALF_W;
            default: addend = WIDE_W'(mul_p) << (2 * HALF_W);
        endcase
    end

    // next partial product that is not trivially zero
    always_comb begin
        nxt_found = 1'b0;
        nxt_k     = 2'd0;
        for (int j = 3; j >= 1; j--) begin
            if (2'(j) > k_reg &&
                part_needed(2'(j), opa_reg[Z_W-1:HALF_W] != '0,
                            opb_reg[Z_W-1:HALF_W] != '0)) begin
                nxt_found = 1'b1;
                nxt_k     = 2'(j);
            end
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        phase_next     = phase_reg;
        limit_cfg_next = limit_cfg_reg;
        radius_next    = radius_reg;
        m_valid_next   = m_valid_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        re_next        = re_reg;
        im_next        = im_reg;
        nr_next        = nr_reg;
        neg_next       = neg_reg;
        escaped_next   = escaped_reg;
        count_next     = count_reg;
        limit_next     = limit_reg;
        tmp_next       = tmp_reg;
        acc_next       = acc_reg;
        lv_next        = lv_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        k_next         = k_reg;
        pend_sh_next   = pend_sh_reg;
        pend_vld_next  = pend_vld_reg;
        sh_next        = sh_reg;
        p_next         = p_reg;
        stage_next     = stage_reg;
        x_next         = x_reg;
        frac_next      = frac_reg;
        step_next      = step_reg;
        second_next    = second_reg;
        g0_next        = g0_reg;
        g1_next        = g1_reg;
        g2_next        = g2_reg;
        mu_next        = mu_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        oc_next        = oc_reg;
        oe_next        = oe_reg;
        osm_next       = osm_reg;
        ocr_next       = ocr_reg;
        or0_next       = or0_reg;
        or1_next       = or1_reg;

        diff_w   = tmp_reg - acc_reg;
        signed_p = neg_reg ? (~acc_reg + WIDE_W'(1)) : acc_reg;
        cnt_inc  = count_reg + COUNT_BITS'(1);
        amt      = (WIDE_W / 2) >> stage_reg;
        topz     = (lv_reg >> (WIDE_W - amt)) == '0;
        shifted  = topz ? (lv_reg << amt) : lv_reg;
        sh_new   = topz ? sh_reg + SH_W'(amt) : sh_reg;
        lg_diff  = second_reg ? DIFF_W'(p_reg) - DIFF_W'(LOG_FRAC)
                              : DIFF_W'(p_reg) - DIFF_W'(2 * FRACTION_BITS);
        lg_res   = {{(VAL_W - DIFF_W - LOG_FRAC){lg_diff[DIFF_W-1]}}, lg_diff, frac_reg};
        lg_l     = (lg_res < VAL_W'(1)) ? VAL_W'(1) : lg_res;
        cnt_val  = VAL_W'(count_reg) <<< LOG_FRAC;
        c16      = mu_reg - r0_reg - r1_reg;

        // configuration writes
        if (cfg_we) begin
            case (cfg_addr)
                CFG_ITER_LIMIT: limit_cfg_next = cfg_wdata[LIMIT_W-1:0];
                CFG_RADIUS:     radius_next    = cfg_wdata[RADIUS_W-1:0];
                default:        ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cr_next      = c_re_ext;
                    ci_next      = c_im_ext;
                    re_next      = c_re_ext;
                    im_next      = c_im_ext;
                    count_next   = COUNT_BITS'(1);
                    limit_next   = COUNT_BITS'(limit_cfg_reg);
                    phase_next   = PH_LOOP;
                    escaped_next = 1'b0;
                    if (COUNT_BITS'(limit_cfg_reg) <= COUNT_BITS'(1)) begin
                        state_next = S_FIN2;
                    end else begin
                        state_next = S_IT_RR;
                    end
                end
            end
            // z*z + c, one product per call of the multiply sequence
            S_IT_RR: begin
                opa_next = mag(re_reg); opb_next = mag(re_reg);
                k_next = 2'd0; acc_next = '0; pend_vld_next = 1'b0;
                ret_next = S_IT_II; state_next = S_MUL;
            end
            S_IT_II: begin
                tmp_next = acc_reg;
                opa_next = mag(im_reg); opb_next = mag(im_reg);
                k_next = 2'd0; acc_next = '0; pend_vld_next = 1'b0;
                ret_next = S_IT_RI; state_next = S_MUL;
            end
            S_IT_RI: begin
                nr_next  = Z_W'(diff_w[FRACTION_BITS +: Z_W]) + cr_reg;
                neg_next = re_reg[Z_W-1] ^ im_reg[Z_W-1];
                opa_next = mag(re_reg); opb_next = mag(im_reg);
                k_next = 2'd0; acc_next = '0; pend_vld_next = 1'b0;
                ret_next = S_IT_NR; state_next = S_MUL;
            end
            S_IT_NR: begin
                re_next  = nr_reg;
                im_next  = Z_W'(signed_p[FRACTION_BITS-1 +: Z_W]) + ci_reg;
                opa_next = mag(nr_reg); opb_next = mag(nr_reg);
                k_next = 2'd0; acc_next = '0; pend_vld_next = 1'b0;
                ret_next = S_IT_NI; state_next = S_MUL;
            end
            S_IT_NI: begin
                tmp_next = acc_reg;
                opa_next = mag(im_reg); opb_next = mag(im_reg);
                k_next = 2'd0; acc_next = '0; pend_vld_next = 1'b0;
                ret_next = S_IT_CHK; state_next = S_MUL;
            end
            S_IT_CHK: begin
                lv_next    = tmp_reg + acc_reg;
                state_next = S_IT_CMP;
            end
            // escape test, or hand |z|^2 to the log unit after escape
            S_IT_CMP: begin
                second_next = 1'b0;
                if (phase_reg == PH_LOOP) begin
                    if (lv_reg > rad_wide) begin
                        escaped_next = 1'b1;
                        phase_next   = PH_G0;
                        state_next   = S_LG_START;
                    end else begin
                        count_next = cnt_inc;
                        state_next = (cnt_inc < limit_reg) ? S_IT_RR : S_FIN2;
                    end
                end else begin
                    state_next = S_LG_START;
                end
            end
            S_LG_START: begin
                if (lv_reg == '0) begin
                    lv_next = WIDE_W'(1);
                end
                sh_next    = '0;
                stage_next = '0;
                state_next = S_LG_NORM;
            end
            // binary-search normalize: shift by 64, 32, ... 1
            S_LG_NORM: begin
                lv_next = shifted;
                sh_next = sh_new;
                if (stage_reg == STG_W'(NORM_STAGES - 1)) begin
                    x_next     = shifted[WIDE_W-1 -: Z_W];
                    p_next     = SH_W'(WIDE_W - 1) - sh_new;
                    frac_next  = '0;
                    step_next  = '0;
                    state_next = S_LG_SQ;
                end else begin
                    stage_next = stage_reg + STG_W'(1);
                end
            end
            S_LG_SQ: begin
                opa_next = x_reg; opb_next = x_reg;
                k_next = 2'd0; acc_next = '0; pend_vld_next = 1'b0;
                ret_next = S_LG_UPD; state_next = S_MUL;
            end
            // one fraction bit per squaring
            S_LG_UPD: begin
                frac_next = {frac_reg[LOG_FRAC-2:0], acc_reg[WIDE_W-1]};
                x_next    = acc_reg[WIDE_W-1] ? acc_reg[WIDE_W-1 -: Z_W]
                                              : acc_reg[WIDE_W-2 -: Z_W];
                step_next = step_reg + STEP_W'(1);
                state_next = (step_reg == STEP_W'(LOG_FRAC - 1)) ? S_LG_END : S_LG_SQ;
            end
            S_LG_END: begin
                if (!second_reg) begin
                    // inner log done; clamp and take log2 again
                    lv_next     = {{(WIDE_W - VAL_W){1'b0}}, lg_l};
                    second_next = 1'b1;
                    state_next  = S_LG_START;
                end else begin
                    case (phase_reg)
                        PH_G0: begin
                            g0_next = lg_res + LOG_CONST; phase_next = PH_G1;
                            state_next = S_IT_RR;
                        end
                        PH_G1: begin
                            g1_next = lg_res + LOG_CONST; phase_next = PH_G2;
                            state_next = S_IT_RR;
                        end
                        default: begin
                            g2_next = lg_res + LOG_CONST;
                            state_next = S_FIN1;
                        end
                    endcase
                end
            end
            // issue one partial product, accumulate the previous one
            S_MUL: begin
                if (pend_vld_reg) begin
                    acc_next = acc_reg + addend;
                end
                pend_vld_next = 1'b1;
                pend_sh_next  = {1'b0, k_reg[1]} + {1'b0, k_reg[0]};
                if (nxt_found) begin
                    k_next = nxt_k;
                end else begin
                    state_next = S_MULW;
                end
            end
            S_MULW: begin
                acc_next   = acc_reg + addend;
                state_next = ret_reg;
            end
            S_FIN1: begin
                mu_next    = to_q16(cnt_val - g0_reg);
                r0_next    = to_q16(g1_reg - g0_reg - (VAL_W'(1) <<< LOG_FRAC));
                r1_next    = to_q16(g2_reg - g1_reg - (VAL_W'(1) <<< LOG_FRAC));
                state_next = S_FIN2;
            end
            // load the output register once it is free
            S_FIN2: begin
                if (!m_valid_reg || m_ready) begin
                    oc_next = LIMIT_W'(count_reg);
                    oe_next = escaped_reg;
                    if (escaped_reg) begin
                        osm_next = SMOOTH_W'(sat_w(mu_reg, SMOOTH_W));
                        or0_next = RESID_W'(sat_w(r0_reg, RESID_W));
                        or1_next = RESID_W'(sat_w(r1_reg, RESID_W));
                        ocr_next = SMOOTH_W'(sat_w(c16, SMOOTH_W));
                    end else begin
                        osm_next = '0;
                        or0_next = '0;
                        or1_next = '0;
                        ocr_next = '0;
                    end
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            phase_reg     <= PH_LOOP;
            limit_cfg_reg <= LIMIT_RESET;
            radius_reg    <= RADIUS_RESET;
            m_valid_reg   <= 1'b0;
            pend_vld_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            phase_reg     <= phase_next;
            limit_cfg_reg <= limit_cfg_next;
            radius_reg    <= radius_next;
            m_valid_reg   <= m_valid_next;
            pend_vld_reg  <= pend_vld_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cr_reg      <= cr_next;
        ci_reg      <= ci_next;
        re_reg      <= re_next;
        im_reg      <= im_next;
        nr_reg      <= nr_next;
        neg_reg     <= neg_next;
        escaped_reg <= escaped_next;
        count_reg   <= count_next;
        limit_reg   <= limit_next;
        tmp_reg     <= tmp_next;
        acc_reg     <= acc_next;
        lv_reg      <= lv_next;
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        k_reg       <= k_next;
        pend_sh_reg <= pend_sh_next;
        sh_reg      <= sh_next;
        p_reg       <= p_next;
        stage_reg   <= stage_next;
        x_reg       <= x_next;
        frac_reg    <= frac_next;
        step_reg    <= step_next;
        second_reg  <= second_next;
        g0_reg      <= g0_next;
        g1_reg      <= g1_next;
        g2_reg      <= g2_next;
        mu_reg      <= mu_next;
        r0_reg      <= r0_next;
        r1_reg      <= r1_next;
        oc_reg      <= oc_next;
        oe_reg      <= oe_next;
        osm_reg     <= osm_next;
        ocr_reg     <= ocr_next;
        or0_reg     <= or0_next;
        or1_reg     <= or1_next;
    end

endmodule

// ===== hdl/msc_checker.sv =====
// Port-level checks of the smooth escape-count block, bound to its top level.
// Depends on msc_pkg and mandelbrot_smooth_escape.
module msc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [msc_pkg::LIMIT_W-1:0]         m_iteration_count,
    input logic                                m_escaped,
    input logic signed [msc_pkg::SMOOTH_W-1:0] m_smooth_count,
    input logic signed [msc_pkg::RESID_W-1:0]  m_first_residual,
    input logic signed [msc_pkg::RESID_W-1:0]  m_second_residual,
    input logic signed [msc_pkg::SMOOTH_W-1:0] m_corrected_count
);
    import msc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_iteration_count) &&
        $stable(m_escaped) && $stable(m_corrected_count))
        else $error("result changed while stalled");

    // the block is busy right after taking a request
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accept");

    // a point that stays bounded carries no smooth terms
    a_bounded_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_escaped |-> m_smooth_count == '0 && m_first_residual == '0 &&
        m_second_residual == '0 && m_corrected_count == '0)
        else $error("bounded point with nonzero smooth terms");

    // the count starts at one
    a_count_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_iteration_count != '0)
        else $error("zero iteration count");

endmodule

bind mandelbrot_smooth_escape msc_checker u_msc_checker (.*);

// ===== tb/mandelbrot_smooth_escape_tb.sv =====
// Self-checking testbench for mandelbrot_smooth_escape: fixed-point predictor,
// burst driver, stalling receiver. Depends on hdl/msc_pkg.sv and the block's RTL.
`timescale 1ns / 1ps

module mandelbrot_smooth_escape_tb;
    import msc_pkg::*;

    typedef struct packed {
        logic signed [IN_W-1:0] c_real;
        logic signed [IN_W-1:0] c_imag;
    } point_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]         iteration_count;
        logic                       escaped;
        logic signed [SMOOTH_W-1:0] smooth_count;
        logic signed [RESID_W-1:0]  first_residual;
        logic signed [RESID_W-1:0]  second_residual;
        logic signed [SMOOTH_W-1:0] corrected_count;
    } escape_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_ITER_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [IN_W-1:0] s_c_real = '0;
    logic signed [IN_W-1:0] s_c_imag = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [LIMIT_W-1:0] m_iteration_count;
    logic m_escaped;
    logic signed [SMOOTH_W-1:0] m_smooth_count;
    logic signed [RESID_W-1:0]  m_first_residual;
    logic signed [RESID_W-1:0]  m_second_residual;
    logic signed [SMOOTH_W-1:0] m_corrected_count;

    mandelbrot_smooth_escape uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_c_real(s_c_real), .s_c_imag(s_c_imag),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_iteration_count(m_iteration_count), .m_escaped(m_escaped),
        .m_smooth_count(m_smooth_count), .m_first_residual(m_first_residual),
        .m_second_residual(m_second_residual), .m_corrected_count(m_corrected_count)
    );

    // testbench copy of the configuration
    logic [LIMIT_W-1:0]  iter_limit = LIMIT_RESET;
    logic [RADIUS_W-1:0] radius_sq  = RADIUS_RESET;

    point_t  pending_points[$];
    escape_t expected_escapes[$];
    int      error_count = 0;
    logic    req_taken = 1'b0;
    int      burst_left = 0;
    int      gap_left = 0;
    int      stall_mode = 0;
    int      stall_tick = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ---------------- predictor ----------------
    function automatic longint clamp64(logic signed [127:0] v);
        if (v > 128'sh7FFFFFFFFFFFFFFF) return 64'sh7FFFFFFFFFFFFFFF;
        if (v < -128'sh8000000000000000) return -64'sh8000000000000000;
        return longint'(v);
    endfunction

    // z = z*z + c; returns exact |z|^2 with 2*FRACTION_BITS fraction bits
    function automatic logic [127:0] square_add(inout longint re, inout longint im,
                                                input longint cr, input longint ci);
        logic signed [127:0] wr, wi, rr, ii, ri;
        wr = re;
        wi = im;
        rr = wr * wr;
        ii = wi * wi;
        ri = wr * wi;
        re = clamp64(128'(clamp64((rr - ii) >>> FRACTION_BITS)) + 128'(cr));
        im = clamp64(128'(clamp64(ri >>> (FRACTION_BITS - 1))) + 128'(ci));
        wr = re;
        wi = im;
        return wr * wr + wi * wi;
    endfunction

    // log2 with LOG_FRAC fraction bits of an unsigned value with fb fraction bits
    function automatic longint log2_fixed(logic [127:0] v, int fb);
        int p;
        logic [127:0] sh, sq;
        logic [63:0] x;
        longint frac;
        if (v == 0) v = 128'd1;
        p = 0;
        for (int i = 0; i < 128; i++) if (v[i]) p = i;
        sh = v << (127 - p);
        x = sh[127:64];
        frac = 0;
        for (int k = 0; k < LOG_FRAC; k++) begin
            sq = {64'd0, x} * {64'd0, x};
            frac = frac << 1;
            if (sq[127]) begin
                x = sq[127:64];
                frac = frac | 1;
            end else begin
                x = sq[126:63];
            end
        end
        return longint'(p - fb) * (longint'(1) << LOG_FRAC) + frac;
    endfunction

    function automatic longint log_log_term(logic [127:0] m);
        longint l;
        l = log2_fixed(m, 2 * FRACTION_BITS);
        if (l < 1) l = 1;
        return log2_fixed(128'(l), LOG_FRAC) + longint'(LOG_CONST);
    endfunction

    function automatic longint round_q16(longint v);
        return (v + (longint'(1) << (LOG_FRAC - 17))) >>> (LOG_FRAC - 16);
    endfunction

    function automatic longint clamp_width(longint v, int w);
        longint hi;
        hi = (longint'(1) << (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic escape_t predict_escape(point_t pt);
        escape_t r;
        longint cr, ci, re, im, g0, g1, g2, mu, r0, r1, one;
        logic [127:0] m, rad;
        int count;
        cr = longint'(pt.c_real) >>> (IN_FRAC - FRACTION_BITS);
        ci = longint'(pt.c_imag) >>> (IN_FRAC - FRACTION_BITS);
        re = cr;
        im = ci;
        m = '0;
        rad = 128'(radius_sq) << (2 * FRACTION_BITS - 16);
        r = '0;
        count = 1;
        while (count < int'(iter_limit)) begin
            m = square_add(re, im, cr, ci);
            if (m > rad) begin
                r.escaped = 1'b1;
                break;
            end
            count++;
        end
        r.iteration_count = LIMIT_W'(count);
        if (r.escaped) begin
            one = longint'(1) << LOG_FRAC;
            g0 = log_log_term(m);
            g1 = log_log_term(square_add(re, im, cr, ci));
            g2 = log_log_term(square_add(re, im, cr, ci));
            mu = round_q16(longint'(count) * one - g0);
            r0 = round_q16(g1 - g0 - one);
            r1 = round_q16(g2 - g1 - one);
            r.smooth_count    = SMOOTH_W'(clamp_width(mu, SMOOTH_W));
            r.first_residual  = RESID_W'(clamp_width(r0, RESID_W));
            r.second_residual = RESID_W'(clamp_width(r1, RESID_W));
            r.corrected_count = SMOOTH_W'(clamp_width(mu - r0 - r1, SMOOTH_W));
        end
        return r;
    endfunction

    // ---------------- request driver ----------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_taken) begin
            // hold until accepted
        end else if (gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_points.size() > 0) begin
            point_t pt;
            pt = pending_points.pop_front();
            s_c_real <= pt.c_real;
            s_c_imag <= pt.c_imag;
            s_valid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 8);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver stall pattern, chosen at random from four modes
    always @(negedge aclk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 128 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) == 0);
            2: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= stall_tick[3];
        endcase
    end

    // accept requests, predict, check results
    always @(posedge aclk) begin
        req_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            expected_escapes.push_back(predict_escape('{s_c_real, s_c_imag}));
        if (aresetn && m_valid && m_ready) begin
            escape_t got, want;
            got = '{m_iteration_count, m_escaped, m_smooth_count, m_first_residual,
                    m_second_residual, m_corrected_count};
            if (expected_escapes.size() == 0) begin
                error_count <= error_count + 1;
                if (error_count < 10) $display("unexpected result: %p", got);
            end else begin
                want = expected_escapes.pop_front();
                if (got !== want) begin
                    error_count <= error_count + 1;
                    if (error_count < 10)
                        $display("mismatch: count %0d/%0d esc %0d/%0d mu %0d/%0d r0 %0d/%0d r1 %0d/%0d corr %0d/%0d (exp/act)",
                            want.iteration_count, got.iteration_count,
                            want.escaped, got.escaped,
                            want.smooth_count, got.smooth_count,
                            want.first_residual, got.first_residual,
                            want.second_residual, got.second_residual,
                            want.corrected_count, got.corrected_count);
                end
            end
        end
    end

    // ---------------- sequencing ----------------
    function automatic point_t random_point();
        point_t pt;
        case ($urandom_range(0, 9))
            0, 1: begin
                pt.c_real = $urandom;
                pt.c_imag = $urandom;
            end
            2: begin
                // near the boundary of the period-2 bulb
                pt.c_real = $signed($urandom_range(0, 200_000_000)) - 32'sd700_000_000;
                pt.c_imag = $signed($urandom_range(0, 400_000_000)) - 32'sd200_000_000;
            end
            default: begin
                pt.c_real = $signed($urandom_range(0, 1_610_612_736)) - 32'sd1_181_116_006;
                pt.c_imag = $signed($urandom_range(0, 1_395_864_370)) - 32'sd697_932_185;
            end
        endcase
        return pt;
    endfunction

    task automatic drain();
        while (pending_points.size() > 0 || s_valid || expected_escapes.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_ITER_LIMIT) iter_limit = val[LIMIT_W-1:0];
        else radius_sq = val[RADIUS_W-1:0];
    endtask

    task automatic run_phase(int lim, int rad, int n);
        drain();
        write_reg(CFG_ITER_LIMIT, CFG_DATA_W'(lim));
        write_reg(CFG_RADIUS, CFG_DATA_W'(rad));
        repeat (n) pending_points.push_back(random_point());
        drain();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed points under the reset configuration
        pending_points.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF});
        pending_points.push_back('{32'sh80000000, 32'sh80000000});
        pending_points.push_back('{32'sh7FFFFFFF, 32'sh80000000});
        pending_points.push_back('{32'sh00000000, 32'sh00000000});   // never escapes
        pending_points.push_back('{-32'sd1073741824, 32'sh0});       // -2: stays at radius
        pending_points.push_back('{-32'sd536870912, 32'sh0});        // -1: period 2
        pending_points.push_back('{32'sd536870912, 32'sh0});         // 1: escapes fast
        pending_points.push_back('{32'sd161061274, 32'sd268435456}); // slow escape
        pending_points.push_back('{32'sh0, 32'sd1073741824});        // 2i
        pending_points.push_back('{32'sh1, 32'shFFFFFFFF});
        pending_points.push_back('{32'sd134217728, -32'sd322122547});
        drain();

        // limit one: no iteration at all
        write_reg(CFG_ITER_LIMIT, CFG_DATA_W'(1));
        pending_points.push_back('{32'sd536870912, 32'sd536870912});
        pending_points.push_back('{32'sh80000000, 32'sh7FFFFFFF});
        pending_points.push_back('{32'sh0, 32'sh0});

        // limit two and radius 16777216 first, then further random phases
        run_phase(2, 16777216, 30);
        run_phase(1023, 16777216, 6);
        run_phase(1023, 262144, 4);
        run_phase(12, 262144, 200);
        run_phase(24, 1000000, 180);
        run_phase(1, 5000000, 30);
        run_phase(16, 16777216, 150);
        run_phase(32, 262144 + 4096, 120);

        drain();
        repeat (200) @(posedge aclk);
        if (error_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #400_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/msc_pkg.sv
hdl/msc_mul.sv
hdl/mandelbrot_smooth_escape.sv
hdl/msc_checker.sv
tb/mandelbrot_smooth_escape_tb.sv
